// ----- sv/dtt_pkg.sv -----
// dtt_pkg: request mode codes, sequencer states and scan kinds for the
// deadline timer table. No dependencies.
`default_nettype none

package dtt_pkg;

  // request modes
  localparam logic [2:0] MODE_ADD     = 3'd0;
  localparam logic [2:0] MODE_CANCEL  = 3'd1;
  localparam logic [2:0] MODE_REFRESH = 3'd2;
  localparam logic [2:0] MODE_RESET   = 3'd3;
  localparam logic [2:0] MODE_EXPIRE  = 3'd4;
  localparam logic [2:0] MODE_QUERY   = 3'd5;

  // rollover window after reset: one hour in ms
  localparam logic [31:0] WINDOW_RESET = 32'(60 * 60 * 1000);

  // width of the interval_ms result field
  localparam int IV_BITS = 48;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FREE,
    ST_ADD_WR,
    ST_REFRESH_WR,
    ST_RESET_CHK,
    ST_RESET_WR,
    ST_SCAN,
    ST_POST,
    ST_FIRE
  } state_t;

  // what one pass over the slots looks for
  typedef enum logic [1:0] {
    SK_EARLIEST,
    SK_DUE,
    SK_MINDUE
  } scan_kind_t;

endpackage

`default_nettype wire

// ----- sv/deadline_timer_table_top.sv -----
// deadline_timer_table_top: timer slot table with a slot-serial compare unit.
// Depends on dtt_pkg (modes, states, scan kinds).
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+--------------------------
//  request  | in_mode in_now_ms in_slot in_period_ms  | start && !busy
//           | in_repeat_req in_restart_now            |
//  result   | out_ok out_result_slot out_interval_ms  | out_valid, one cycle,
//           | out_front_notify out_fired out_last     | no back pressure
//  config   | cfg_rollover_window_ms                  | cfg_valid && cfg_ready
//
// Cancel, failed refresh, unused modes, refresh and a reset that ends at its check
// give their result without a slot scan. A slot scan reads one memory entry per
// cycle. Query and an expire check run a scan, reset runs one after its check, and
// add runs one after a free-slot search, which ends with a failed result on a
// full table. An expire check with due slots runs a further scan after each fired
// slot but the last. Reset clears all slots to inactive at once; no clearing pass
// is needed. busy drops in the cycle of the last result; the receiver cannot stall
// results.
`default_nettype none

module deadline_timer_table_top #(
  parameter int TIMER_SLOTS = 16,
  parameter int TIME_BITS   = 48
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_mode,
  input  wire logic [47:0] in_now_ms,
  input  wire logic [3:0]  in_slot,
  input  wire logic [47:0] in_period_ms,
  input  wire logic        in_repeat_req,
  input  wire logic        in_restart_now,
  // result
  output logic             out_valid,
  output logic             out_ok,
  output logic [3:0]       out_result_slot,
  output logic [47:0]      out_interval_ms,
  output logic             out_front_notify,
  output logic             out_fired,
  output logic             out_last,
  // config
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_rollover_window_ms
);

  localparam int IDX_W = $clog2(TIMER_SLOTS);
  localparam int CNT_W = IDX_W + 1;
  localparam int IV_W  = dtt_pkg::IV_BITS;

  typedef logic [TIME_BITS-1:0] tm_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  // now plus period, saturating at all ones
  function automatic tm_t sat_add(input tm_t a, input tm_t b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
  endfunction

  // slot memories; period entry carries the repeat flag on top
  tm_t                  dl_mem [TIMER_SLOTS];
  logic [TIME_BITS:0]   pr_mem [TIMER_SLOTS];
  tm_t                  dl_rd_r;
  logic [TIME_BITS:0]   pr_rd_r;

  logic [TIMER_SLOTS-1:0] active_r;
  logic [TIMER_SLOTS-1:0] due_r;

  // request fields
  logic [2:0] mode_r;
  tm_t        now_r;
  logic [3:0] slot_r;
  tm_t        per_r;
  logic       rep_r;
  logic       fnow_r;
  logic       slot_vld_r;

  // sequencer state
  dtt_pkg::state_t     state_r, state_nxt;
  dtt_pkg::scan_kind_t kind_r, kind_nxt;
  cnt_t       cnt_r, cnt_nxt;
  idx_t       tgt_r, tgt_nxt;
  logic       best_found_r, best_found_nxt;
  idx_t       best_idx_r, best_idx_nxt;
  tm_t        best_dl_r, best_dl_nxt;
  logic [TIME_BITS:0] best_pr_r, best_pr_nxt;
  logic       any_r, any_nxt;
  cnt_t       due_cnt_r, due_cnt_nxt;
  cnt_t       fire_cnt_r, fire_cnt_nxt;
  logic       roll_r, roll_nxt;
  tm_t        start_r, start_nxt;
  logic       noticed_r, noticed_nxt;
  tm_t        last_check_r, last_check_nxt;
  logic [31:0] window_r;

  // write strobes and result to send
  logic               dl_we, pr_we;
  idx_t               dl_wa, pr_wa;
  tm_t                dl_wd;
  logic [TIME_BITS:0] pr_wd;
  idx_t               rd_addr;
  logic               act_set, act_clr;
  idx_t               act_idx;
  logic               due_we, due_val;
  idx_t               due_idx;
  logic               emit, e_ok, e_fn, e_fi, e_last;
  logic [3:0]         e_slot;
  logic [IV_W-1:0]    e_iv;

  // scan helpers
  logic  accept;
  logic  slot_vld_in;
  cnt_t  cnt_m1;
  idx_t  ci;
  logic  cand;
  logic  scan_go;
  cnt_t  fire_inc;
  logic  is_last;

  assign accept      = start && !busy;
  assign busy        = (state_r != dtt_pkg::ST_IDLE);
  assign cfg_ready   = 1'b1;
  assign slot_vld_in = (32'(in_slot) < 32'(TIMER_SLOTS));
  assign cnt_m1      = cnt_r - cnt_t'(1);
  assign ci          = cnt_m1[IDX_W-1:0];
  assign fire_inc    = fire_cnt_r + cnt_t'(1);
  assign is_last     = (fire_inc == due_cnt_r);
  assign rd_addr     = (state_r == dtt_pkg::ST_SCAN) ? cnt_r[IDX_W-1:0] : tgt_r;

  // slot memories, registered read
  always_ff @(posedge clk) begin
    if (dl_we) dl_mem[dl_wa] <= dl_wd;
    if (pr_we) pr_mem[pr_wa] <= pr_wd;
    dl_rd_r <= dl_mem[rd_addr];
    pr_rd_r <= pr_mem[rd_addr];
  end

  // request capture on transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r     <= in_mode;
      now_r      <= TIME_BITS'(in_now_ms);
      slot_r     <= in_slot;
      per_r      <= TIME_BITS'(in_period_ms);
      rep_r      <= in_repeat_req;
      fnow_r     <= in_restart_now;
      slot_vld_r <= slot_vld_in;
    end
  end

  // active and due flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      due_r    <= '0;
    end else begin
      if (act_set) active_r[act_idx] <= 1'b1;
      if (act_clr) active_r[act_idx] <= 1'b0;
      if (due_we)  due_r[due_idx]    <= due_val;
    end
  end

  // rollover window register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= dtt_pkg::WINDOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      window_r <= cfg_rollover_window_ms;
    end
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dtt_pkg::ST_IDLE;
      kind_r       <= dtt_pkg::SK_EARLIEST;
      cnt_r        <= '0;
      noticed_r    <= 1'b0;
      last_check_r <= '0;
      best_found_r <= 1'b0;
      any_r        <= 1'b0;
      due_cnt_r    <= '0;
      fire_cnt_r   <= '0;
      roll_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      kind_r       <= kind_nxt;
      cnt_r        <= cnt_nxt;
      noticed_r    <= noticed_nxt;
      last_check_r <= last_check_nxt;
      best_found_r <= best_found_nxt;
      any_r        <= any_nxt;
      due_cnt_r    <= due_cnt_nxt;
      fire_cnt_r   <= fire_cnt_nxt;
      roll_r       <= roll_nxt;
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    tgt_r      <= tgt_nxt;
    best_idx_r <= best_idx_nxt;
    best_dl_r  <= best_dl_nxt;
    best_pr_r  <= best_pr_nxt;
    start_r    <= start_nxt;
  end

  // next state, memory writes and result
  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    cnt_nxt        = cnt_r;
    tgt_nxt        = tgt_r;
    best_found_nxt = best_found_r;
    best_idx_nxt   = best_idx_r;
    best_dl_nxt    = best_dl_r;
    best_pr_nxt    = best_pr_r;
    any_nxt        = any_r;
    due_cnt_nxt    = due_cnt_r;
    fire_cnt_nxt   = fire_cnt_r;
    roll_nxt       = roll_r;
    start_nxt      = start_r;
    noticed_nxt    = noticed_r;
    last_check_nxt = last_check_r;
    dl_we   = 1'b0;
    dl_wa   = tgt_r;
    dl_wd   = sat_add(now_r, per_r);
    pr_we   = 1'b0;
    pr_wa   = tgt_r;
    pr_wd   = {rep_r, per_r};
    act_set = 1'b0;
    act_clr = 1'b0;
    act_idx = tgt_r;
    due_we  = 1'b0;
    due_val = 1'b0;
    due_idx = ci;
    emit    = 1'b0;
    e_ok    = 1'b0;
    e_slot  = '0;
    e_iv    = '0;
    e_fn    = 1'b0;
    e_fi    = 1'b0;
    e_last  = 1'b1;
    cand    = 1'b0;
    scan_go = 1'b0;

    case (state_r)
      dtt_pkg::ST_IDLE: begin
        if (start) begin
          tgt_nxt   = slot_vld_in ? idx_t'(in_slot) : '0;
          state_nxt = dtt_pkg::ST_DECODE;
        end
      end

      dtt_pkg::ST_DECODE: begin
        case (mode_r)
          dtt_pkg::MODE_ADD: begin
            cnt_nxt   = '0;
            state_nxt = dtt_pkg::ST_FREE;
          end
          dtt_pkg::MODE_CANCEL: begin
            emit   = 1'b1;
            e_slot = slot_r;
            if (slot_vld_r && active_r[tgt_r]) begin
              act_clr = 1'b1;
              e_ok    = 1'b1;
            end
            state_nxt = dtt_pkg::ST_IDLE;
          end
          dtt_pkg::MODE_REFRESH: begin
            if (slot_vld_r && active_r[tgt_r]) begin
              state_nxt = dtt_pkg::ST_REFRESH_WR;
            end else begin
              emit      = 1'b1;
              e_slot    = slot_r;
              state_nxt = dtt_pkg::ST_IDLE;
            end
          end
          dtt_pkg::MODE_RESET: begin
            if (slot_vld_r) begin
              state_nxt = dtt_pkg::ST_RESET_CHK;
            end else begin
              emit      = 1'b1;
              e_slot    = slot_r;
              state_nxt = dtt_pkg::ST_IDLE;
            end
          end
          dtt_pkg::MODE_EXPIRE: begin
            roll_nxt     = (now_r < last_check_r) &&
                           ((last_check_r - now_r) > TIME_BITS'(window_r));
            due_cnt_nxt  = '0;
            fire_cnt_nxt = '0;
            kind_nxt     = dtt_pkg::SK_DUE;
            scan_go      = 1'b1;
          end
          dtt_pkg::MODE_QUERY: begin
            noticed_nxt = 1'b0;
            kind_nxt    = dtt_pkg::SK_EARLIEST;
            scan_go     = 1'b1;
          end
          default: begin
            emit      = 1'b1;
            state_nxt = dtt_pkg::ST_IDLE;
          end
        endcase
      end

      // lowest free slot, one flag per cycle
      dtt_pkg::ST_FREE: begin
        if (!active_r[cnt_r[IDX_W-1:0]]) begin
          tgt_nxt   = cnt_r[IDX_W-1:0];
          state_nxt = dtt_pkg::ST_ADD_WR;
        end else if (cnt_r == cnt_t'(TIMER_SLOTS - 1)) begin
          emit      = 1'b1;
          state_nxt = dtt_pkg::ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + cnt_t'(1);
        end
      end

      dtt_pkg::ST_ADD_WR: begin
        dl_we    = 1'b1;
        pr_we    = 1'b1;
        act_set  = 1'b1;
        kind_nxt = dtt_pkg::SK_EARLIEST;
        scan_go  = 1'b1;
      end

      dtt_pkg::ST_REFRESH_WR: begin
        dl_we     = 1'b1;
        dl_wd     = sat_add(now_r, pr_rd_r[TIME_BITS-1:0]);
        emit      = 1'b1;
        e_ok      = 1'b1;
        e_slot    = slot_r;
        state_nxt = dtt_pkg::ST_IDLE;
      end

      // reset: unchanged period counted from the old start is a no-op
      dtt_pkg::ST_RESET_CHK: begin
        if (per_r == pr_rd_r[TIME_BITS-1:0] && !fnow_r) begin
          emit      = 1'b1;
          e_ok      = 1'b1;
          e_slot    = slot_r;
          state_nxt = dtt_pkg::ST_IDLE;
        end else if (!active_r[tgt_r]) begin
          emit      = 1'b1;
          e_slot    = slot_r;
          state_nxt = dtt_pkg::ST_IDLE;
        end else begin
          if (fnow_r) begin
            start_nxt = now_r;
          end else if (dl_rd_r >= pr_rd_r[TIME_BITS-1:0]) begin
            start_nxt = dl_rd_r - pr_rd_r[TIME_BITS-1:0];
          end else begin
            start_nxt = '0;
          end
          state_nxt = dtt_pkg::ST_RESET_WR;
        end
      end

      dtt_pkg::ST_RESET_WR: begin
        dl_we    = 1'b1;
        dl_wd    = sat_add(start_r, per_r);
        pr_we    = 1'b1;
        pr_wd    = {pr_rd_r[TIME_BITS], per_r};
        kind_nxt = dtt_pkg::SK_EARLIEST;
        scan_go  = 1'b1;
      end

      // issue slot cnt, compare slot cnt-1 against the running best
      dtt_pkg::ST_SCAN: begin
        if (cnt_r != '0) begin
          case (kind_r)
            dtt_pkg::SK_EARLIEST: cand = active_r[ci];
            dtt_pkg::SK_DUE:      cand = active_r[ci] && (roll_r || dl_rd_r <= now_r);
            dtt_pkg::SK_MINDUE:   cand = due_r[ci];
            default:              cand = 1'b0;
          endcase
          if (kind_r == dtt_pkg::SK_DUE) begin
            due_we  = 1'b1;
            due_val = cand;
            if (cand) due_cnt_nxt = due_cnt_r + cnt_t'(1);
            if (active_r[ci]) any_nxt = 1'b1;
          end
          if (cand && (!best_found_r || dl_rd_r < best_dl_r)) begin
            best_found_nxt = 1'b1;
            best_idx_nxt   = ci;
            best_dl_nxt    = dl_rd_r;
            best_pr_nxt    = pr_rd_r;
          end
        end
        if (cnt_r == cnt_t'(TIMER_SLOTS)) begin
          state_nxt = dtt_pkg::ST_POST;
        end else begin
          cnt_nxt = cnt_r + cnt_t'(1);
        end
      end

      dtt_pkg::ST_POST: begin
        case (kind_r)
          dtt_pkg::SK_EARLIEST: begin
            emit      = 1'b1;
            e_ok      = 1'b1;
            state_nxt = dtt_pkg::ST_IDLE;
            if (mode_r == dtt_pkg::MODE_QUERY) begin
              if (best_found_r) begin
                e_slot = 4'(best_idx_r);
                e_iv   = (now_r >= best_dl_r) ? '0 : IV_W'(best_dl_r - now_r);
              end else begin
                e_iv = '1;
              end
            end else begin
              // add or reset: notice when the new slot is in front
              e_slot = (mode_r == dtt_pkg::MODE_ADD) ? 4'(tgt_r) : slot_r;
              if (best_found_r && best_idx_r == tgt_r && !noticed_r) begin
                e_fn        = 1'b1;
                noticed_nxt = 1'b1;
              end
            end
          end
          dtt_pkg::SK_DUE: begin
            if (!any_r) begin
              emit      = 1'b1;
              e_ok      = 1'b1;
              state_nxt = dtt_pkg::ST_IDLE;
            end else begin
              last_check_nxt = now_r;
              if (due_cnt_r == '0) begin
                emit      = 1'b1;
                e_ok      = 1'b1;
                state_nxt = dtt_pkg::ST_IDLE;
              end else begin
                state_nxt = dtt_pkg::ST_FIRE;
              end
            end
          end
          default: begin
            state_nxt = dtt_pkg::ST_FIRE;
          end
        endcase
      end

      // report the earliest pending due slot, then rearm or free it
      dtt_pkg::ST_FIRE: begin
        emit         = 1'b1;
        e_ok         = 1'b1;
        e_fi         = 1'b1;
        e_slot       = 4'(best_idx_r);
        e_last       = is_last;
        fire_cnt_nxt = fire_inc;
        due_we       = 1'b1;
        due_val      = 1'b0;
        due_idx      = best_idx_r;
        act_idx      = best_idx_r;
        dl_wa        = best_idx_r;
        if (best_pr_r[TIME_BITS]) begin
          dl_we = 1'b1;
          dl_wd = sat_add(now_r, best_pr_r[TIME_BITS-1:0]);
        end else begin
          act_clr = 1'b1;
        end
        if (is_last) begin
          state_nxt = dtt_pkg::ST_IDLE;
        end else begin
          kind_nxt = dtt_pkg::SK_MINDUE;
          scan_go  = 1'b1;
        end
      end

      default: begin
        state_nxt = dtt_pkg::ST_IDLE;
      end
    endcase

    // start of a slot pass
    if (scan_go) begin
      cnt_nxt        = '0;
      best_found_nxt = 1'b0;
      any_nxt        = 1'b0;
      state_nxt      = dtt_pkg::ST_SCAN;
    end
  end

  // result registers, one cycle per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_ok           <= e_ok;
      out_result_slot  <= e_slot;
      out_interval_ms  <= e_iv;
      out_front_notify <= e_fn;
      out_fired        <= e_fi;
      out_last         <= e_last;
    end
  end

endmodule

`default_nettype wire

// ----- sv/dtt_checker.sv -----
// dtt_checker: port-level checks on deadline_timer_table_top, with its bind.
// Depends on deadline_timer_table_top's port list only.
`default_nettype none

module dtt_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       out_valid,
  input wire logic       out_ok,
  input wire logic       out_front_notify,
  input wire logic       out_fired,
  input wire logic       out_last
);

  // a request transfer keeps the block busy in the next cycle
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy low after request transfer");

  // the cycle after a final result carries no result
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result right after final result");

  // only an expire check gives more than one result
  a_multi_is_fire: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_fired && out_ok)
    else $error("non-final result that is not a fired slot");

  // a fired slot is reported with success
  a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fired |-> out_ok && !out_front_notify)
    else $error("fired slot without success");

  // a front notice comes from a successful single-result request
  a_notify_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_front_notify |-> out_ok && out_last)
    else $error("front notice on failed or multi-result request");

endmodule

bind deadline_timer_table_top dtt_checker u_dtt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_ok           (out_ok),
  .out_front_notify (out_front_notify),
  .out_fired        (out_fired),
  .out_last         (out_last)
);

`default_nettype wire

// ----- tb/testbench.sv -----
// testbench: self-checking bench for deadline_timer_table_top with a built-in
// slot table predictor in a small scoreboard class and random request traffic
// depends on dtt_pkg (mode codes, window reset value) and the rtl top level
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int        TIMER_SLOTS = 16;
  localparam bit [47:0] TIME_MAX    = '1;
  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;
  localparam int        STALL_LIMIT = 4000;
  localparam int        DRAIN_CYCLES = 60;
  localparam int        PHASE_ITEMS = 58;

  typedef struct packed {
    logic [2:0]  mode;
    logic [47:0] now_ms;
    logic [3:0]  slot;
    logic [47:0] period_ms;
    logic        repeat_req;
    logic        restart_now;
  } request_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  result_slot;
    logic [47:0] interval_ms;
    logic        front_notify;
    logic        fired;
    logic        last;
  } result_t;

  // shadow timer table and queue of results still owed by the block
  class timer_scoreboard;
    bit [TIMER_SLOTS-1:0] armed;
    bit [TIMER_SLOTS-1:0] written;
    bit [TIMER_SLOTS-1:0] repeats;
    bit [47:0]            deadline [TIMER_SLOTS];
    bit [47:0]            period   [TIMER_SLOTS];
    bit                   front_noticed;
    bit [47:0]            last_check_ms;
    bit [31:0]            window_ms;
    result_t              expected_q[$];
    int                   errors;

    function new();
      window_ms = dtt_pkg::WINDOW_RESET;
    endfunction

    // now plus period, clamped to the largest time
    function bit [47:0] sat_add(bit [47:0] a, bit [47:0] b);
      bit [48:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[48] ? TIME_MAX : sum[47:0];
    endfunction

    // earliest deadline among the masked slots, lower slot wins ties
    function int first_of(bit [TIMER_SLOTS-1:0] mask);
      int best;
      best = -1;
      for (int i = 0; i < TIMER_SLOTS; i++)
        if (mask[i] && (best < 0 || deadline[i] < deadline[best])) best = i;
      return best;
    endfunction

    // notice when a slot just became the front of the table
    function bit take_front(int s);
      if (first_of(armed) == s && !front_noticed) begin
        front_noticed = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // apply one accepted request and queue the results it owes
    function void note_request(request_t r);
      result_t              res;
      bit [TIMER_SLOTS-1:0] due;
      bit [47:0]            start_ms;
      bit [47:0]            dl;
      bit                   roll;
      int                   s;
      int                   e;
      int                   order[$];
      res = '0;
      res.last = 1'b1;
      due = '0;
      s = r.slot;
      case (r.mode)
        dtt_pkg::MODE_ADD: begin
          e = -1;
          for (int i = 0; i < TIMER_SLOTS; i++)
            if (!armed[i] && e < 0) e = i;
          if (e >= 0) begin
            armed[e]    = 1'b1;
            written[e]  = 1'b1;
            deadline[e] = sat_add(r.now_ms, r.period_ms);
            period[e]   = r.period_ms;
            repeats[e]  = r.repeat_req;
            res.ok = 1'b1;
            res.result_slot = 4'(e);
            res.front_notify = take_front(e);
          end
        end
        dtt_pkg::MODE_CANCEL, dtt_pkg::MODE_REFRESH: begin
          res.result_slot = r.slot;
          if (armed[s]) begin
            res.ok = 1'b1;
            if (r.mode == dtt_pkg::MODE_CANCEL) armed[s] = 1'b0;
            else deadline[s] = sat_add(r.now_ms, period[s]);
          end
        end
        dtt_pkg::MODE_RESET: begin
          res.result_slot = r.slot;
          if (r.period_ms == period[s] && !r.restart_now) begin
            res.ok = 1'b1;
          end else if (armed[s]) begin
            if (r.restart_now) start_ms = r.now_ms;
            else start_ms = deadline[s] >= period[s] ? deadline[s] - period[s] : '0;
            period[s]   = r.period_ms;
            deadline[s] = sat_add(start_ms, r.period_ms);
            res.ok = 1'b1;
            res.front_notify = take_front(s);
          end
        end
        dtt_pkg::MODE_QUERY: begin
          front_noticed = 1'b0;
          res.ok = 1'b1;
          e = first_of(armed);
          if (e < 0) begin
            res.interval_ms = TIME_MAX;
          end else begin
            dl = deadline[e];
            res.result_slot = 4'(e);
            res.interval_ms = r.now_ms >= dl ? '0 : dl - r.now_ms;
          end
        end
        dtt_pkg::MODE_EXPIRE: begin
          res.ok = 1'b1;
          if (armed != '0) begin
            roll = r.now_ms < last_check_ms &&
                   (last_check_ms - r.now_ms) > {16'd0, window_ms};
            last_check_ms = r.now_ms;
            for (int i = 0; i < TIMER_SLOTS; i++)
              due[i] = armed[i] && (roll || deadline[i] <= r.now_ms);
            while (due != '0) begin
              e = first_of(due);
              due[e] = 1'b0;
              order.insert(order.size(), e);
            end
            // one result per fired slot, repeating ones rearm from now
            foreach (order[k]) begin
              res.fired = 1'b1;
              res.result_slot = 4'(order[k]);
              res.last = (k == order.size() - 1);
              expected_q.insert(expected_q.size(), res);
              if (repeats[order[k]])
                deadline[order[k]] = sat_add(r.now_ms, period[order[k]]);
              else
                armed[order[k]] = 1'b0;
            end
            if (order.size() > 0) return;
          end
        end
        default: ;
      endcase
      expected_q.insert(expected_q.size(), res);
    endfunction

    function void compare_field(string name, logic [47:0] want, logic [47:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
    endfunction

    // compare one result with the oldest one owed
    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual ok %b slot %0d fired %b",
                 $time, got.ok, got.result_slot, got.fired);
        return;
      end
      want = expected_q.pop_front();
      compare_field("ok", want.ok, got.ok);
      compare_field("result_slot", want.result_slot, got.result_slot);
      compare_field("interval_ms", want.interval_ms, got.interval_ms);
      compare_field("front_notify", want.front_notify, got.front_notify);
      compare_field("fired", want.fired, got.fired);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_mode = '0;
  logic [47:0] in_now_ms = '0;
  logic [3:0]  in_slot = '0;
  logic [47:0] in_period_ms = '0;
  logic        in_repeat_req = 1'b0;
  logic        in_restart_now = 1'b0;
  logic        out_valid;
  logic        out_ok;
  logic [3:0]  out_result_slot;
  logic [47:0] out_interval_ms;
  logic        out_front_notify;
  logic        out_fired;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_rollover_window_ms = '0;

  timer_scoreboard sb;
  bit [47:0]       clock_ms;
  bit              steady;
  int              idle_cycles = 0;

  always #6 clk = ~clk;

  deadline_timer_table_top #(
    .TIMER_SLOTS(TIMER_SLOTS),
    .TIME_BITS  (48)
  ) i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_mode               (in_mode),
    .in_now_ms             (in_now_ms),
    .in_slot               (in_slot),
    .in_period_ms          (in_period_ms),
    .in_repeat_req         (in_repeat_req),
    .in_restart_now        (in_restart_now),
    .out_valid             (out_valid),
    .out_ok                (out_ok),
    .out_result_slot       (out_result_slot),
    .out_interval_ms       (out_interval_ms),
    .out_front_notify      (out_front_notify),
    .out_fired             (out_fired),
    .out_last              (out_last),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_rollover_window_ms(cfg_rollover_window_ms)
  );

  // result monitor, one result per strobe
  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_valid) begin
      got = {out_ok, out_result_slot, out_interval_ms, out_front_notify, out_fired, out_last};
      sb.check_result(got);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic bit [47:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  function automatic request_t req(logic [2:0] mode, bit [47:0] now, bit [3:0] slot,
                                   bit [47:0] per, bit rep, bit fnow);
    return '{mode, now, slot, per, rep, fnow};
  endfunction

  // mostly short gaps, a few long, none during steady stretches
  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (steady || k < 55) return 0;
    if (k < 85) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit [47:0] random_period();
    int k;
    k = $urandom_range(0, 99);
    if (k < 5) return '0;
    if (k < 70) return 48'($urandom_range(1, 2000));
    if (k < 82) return 48'($urandom_range(2001, 200000));
    if (k < 94) return rand48();
    return TIME_MAX;
  endfunction

  // time mostly moves forward, sometimes jumps back or far away
  function automatic void advance_clock();
    int        k;
    bit [47:0] dec;
    k = $urandom_range(0, 99);
    dec = '0;
    if (k < 78) clock_ms = sb.sat_add(clock_ms, 48'($urandom_range(0, 400)));
    else if (k < 86) dec = 48'($urandom_range(0, 3000));
    else if (k < 92) dec = 48'($urandom_range(1000000, 8000000));
    else if (k < 97) clock_ms = rand48();
    else clock_ms = $urandom_range(0, 1) ? TIME_MAX : '0;
    if (dec != '0) clock_ms = clock_ms > dec ? clock_ms - dec : '0;
  endfunction

  // well-formed traffic on live slots, some noise on idle slots and spare codes
  function automatic request_t random_request();
    request_t r;
    int       pick;
    int       s;
    r = req(dtt_pkg::MODE_ADD, clock_ms, 4'($urandom), random_period(), 1'($urandom),
            1'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      r.mode = dtt_pkg::MODE_ADD;
    end else if (pick < 50) begin
      r.mode = dtt_pkg::MODE_EXPIRE;
    end else if (pick < 62) begin
      r.mode = dtt_pkg::MODE_QUERY;
    end else if (pick < 98) begin
      r.mode = pick < 72 ? dtt_pkg::MODE_CANCEL :
               (pick < 84 ? dtt_pkg::MODE_REFRESH : dtt_pkg::MODE_RESET);
      if (sb.armed != '0 && $urandom_range(0, 4) != 0) begin
        do s = $urandom_range(0, TIMER_SLOTS - 1); while (!sb.armed[s]);
        r.slot = 4'(s);
      end
      // never reset a slot whose period was never set
      if (r.mode == dtt_pkg::MODE_RESET) begin
        if (!sb.written[r.slot]) r.mode = dtt_pkg::MODE_ADD;
        else if ($urandom_range(0, 5) == 0) r.period_ms = sb.period[r.slot];
      end
    end else begin
      r.mode = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
    end
    return r;
  endfunction

  task automatic pause(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // one request transfer, then a random gap
  task automatic send(request_t r);
    in_mode        <= r.mode;
    in_now_ms      <= r.now_ms;
    in_slot        <= r.slot;
    in_period_ms   <= r.period_ms;
    in_repeat_req  <= r.repeat_req;
    in_restart_now <= r.restart_now;
    start          <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_request(r);
    pause(pick_gap());
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
  endtask

  task automatic write_window(bit [31:0] w);
    wait_drained();
    cfg_rollover_window_ms <= w;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.window_ms = w;
  endtask

  // hand-picked corner cases on an empty table
  task automatic run_directed();
    send(req(dtt_pkg::MODE_QUERY, 48'd0, 4'd0, 48'd0, 1'b0, 1'b0));
    send(req(dtt_pkg::MODE_EXPIRE, 48'd100, 4'd15, TIME_MAX, 1'b1, 1'b1));
    send(req(MODE_SPARE_A, TIME_MAX, 4'd15, TIME_MAX, 1'b1, 1'b1));
    send(req(MODE_SPARE_B, 48'd0, 4'd0, 48'd0, 1'b0, 1'b0));
    send(req(dtt_pkg::MODE_CANCEL, 48'd500, 4'd3, 48'd0, 1'b0, 1'b0));
    send(req(dtt_pkg::MODE_REFRESH, 48'd500, 4'd5, 48'd0, 1'b0, 1'b0));
    send(req(dtt_pkg::MODE_ADD, 48'd1000, 4'd9, 48'd500, 1'b1, 1'b0));
    send(req(dtt_pkg::MODE_ADD, 48'd1000, 4'd0, TIME_MAX, 1'b0, 1'b1));
    send(req(dtt_pkg::MODE_ADD, TIME_MAX, 4'd0, 48'd0, 1'b1, 1'b0));
    send(req(dtt_pkg::MODE_QUERY, 48'd1200, 4'd0, 48'd0, 1'b0, 1'b0));
    send(req(dtt_pkg::MODE_ADD, 48'd1200, 4'd0, 48'd10, 1'b0, 1'b0));
    send(req(dtt_pkg::MODE_REFRESH, 48'd1300, 4'd3, 48'd0, 1'b0, 1'b0));
    // reset with unchanged period, then from previous start and from now
    send(req(dtt_pkg::MODE_RESET, 48'd1350, 4'd0, 48'd500, 1'b0, 1'b0));
    send(req(dtt_pkg::MODE_RESET, 48'd1350, 4'd0, 48'd100, 1'b0, 1'b0));
    send(req(dtt_pkg::MODE_RESET, 48'd1400, 4'd3, 48'd2000, 1'b0, 1'b1));
    send(req(dtt_pkg::MODE_RESET, 48'd1400, 4'd1, 48'd5, 1'b0, 1'b0));
    send(req(dtt_pkg::MODE_EXPIRE, 48'd1500, 4'd0, 48'd0, 1'b0, 1'b0));
    send(req(dtt_pkg::MODE_CANCEL, 48'd1500, 4'd3, 48'd0, 1'b0, 1'b0));
    send(req(dtt_pkg::MODE_RESET, 48'd1500, 4'd3, 48'd7, 1'b0, 1'b1));
    send(req(dtt_pkg::MODE_RESET, 48'd1500, 4'd3, 48'd2000, 1'b0, 1'b0));
    // small backward jump, far forward, then a rollover
    send(req(dtt_pkg::MODE_EXPIRE, 48'd0, 4'd0, 48'd0, 1'b0, 1'b0));
    send(req(dtt_pkg::MODE_EXPIRE, 48'd5000000, 4'd0, 48'd0, 1'b0, 1'b0));
    send(req(dtt_pkg::MODE_EXPIRE, 48'd10, 4'd0, 48'd0, 1'b0, 1'b0));
    send(req(dtt_pkg::MODE_QUERY, 48'd20, 4'd0, 48'd0, 1'b0, 1'b0));
  endtask

  // fill the table, overflow it, fire everything, then random traffic
  task automatic run_phase(int items);
    request_t r;
    while ($countones(sb.armed) < TIMER_SLOTS) begin
      r = random_request();
      r.mode = dtt_pkg::MODE_ADD;
      send(r);
    end
    r = random_request();
    r.mode = dtt_pkg::MODE_ADD;
    send(r);
    r.mode = dtt_pkg::MODE_EXPIRE;
    r.now_ms = TIME_MAX;
    send(r);
    for (int k = 0; k < items; k++) begin
      if (k % 30 == 0) steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 3) wait_drained();
      advance_clock();
      send(random_request());
    end
  endtask

  // main sequence
  initial begin
    sb = new();
    steady = 1'b0;
    clock_ms = 48'd20000000 + 48'($urandom_range(0, 1000000));
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_phase(PHASE_ITEMS);
    write_window('0);
    run_phase(PHASE_ITEMS);
    write_window('1);
    run_phase(PHASE_ITEMS);
    write_window(32'd1000);
    run_phase(PHASE_ITEMS);
    write_window($urandom);
    run_phase(PHASE_ITEMS);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
